// ===== src/acfp_pkg.sv =====
package acfp_pkg;

    // Character codes.
    localparam logic [7:0] CHAR_CR = 8'h0D;

    // Configuration register indexes.
    localparam logic [7:0] CFG_LINE_TERM     = 8'd0;
    localparam logic [7:0] CFG_CHECKSUM_SEED = 8'd1;

    // Configuration reset values.
    localparam logic [7:0]  LINE_TERM_RESET = 8'd10;
    localparam logic [31:0] SEED_RESET      = 32'd0;

    // Bit positions in the error flags.
    localparam int ERR_CHECKSUM = 0;
    localparam int ERR_EARLY    = 1;
    localparam int ERR_SEQ      = 2;
    localparam int ERR_TOOMANY  = 3;
    localparam int ERR_LENGTH   = 4;

    // Field that the next completed byte fills.
    typedef enum logic [2:0] {
        PH_SEQ,
        PH_ID0,
        PH_ID1,
        PH_ID2,
        PH_ID3,
        PH_LEN,
        PH_DATA,
        PH_DONE
    } t_phase;

    // One parsed frame.
    typedef struct packed {
        logic [7:0]  seq;
        logic [31:0] id;
        logic [3:0]  length;
        logic [63:0] payload;
        logic [4:0]  err;
    } t_frame;

    // Hex digit value; anything that is not a hex digit counts as zero.
    function automatic logic [3:0] nibble_of(input logic [7:0] c);
        logic [3:0] v;
        v = 4'h0;
        if (c inside {[8'h30:8'h39]}) begin
            v = 4'(c - 8'h30);
        end else if (c inside {[8'h41:8'h46]}) begin
            v = 4'(c - 8'h37);
        end else if (c inside {[8'h61:8'h66]}) begin
            v = 4'(c - 8'h57);
        end
        return v;
    endfunction

endpackage

// ===== src/ascii_hex_can_frame_parser.sv =====
// ASCII-hex CAN frame line parser.
// Input channel (i_in_valid / o_in_ready / i_rx_char) takes one received
// character per item. Output channel (o_out_valid / i_out_ready) delivers one
// frame per line terminator: sequence byte, identifier, clamped length,
// payload and error flags. Characters that do not end a line give no item.
// Configuration channel (i_cfg_valid / o_cfg_ready / i_cfg_index / i_cfg_data)
// is always ready; index 0 sets the line terminator, index 1 the checksum seed.
// Order: a character is registered on acceptance and parsed when it leaves the
// input register; the frame of a terminator is registered as it leaves it.
// Throughput: one character per cycle (single parser update stage) unless a terminator stalls.
// When the receiver stalls, the output register holds its frame and ordinary
// characters keep flowing; a second terminator waits in the input register,
// and input ready drops until the output slot frees.
// Reset (synchronous, active low) empties both registers, clears the parser to
// the start of a line and restores the terminator to line feed and seed to 0.
module ascii_hex_can_frame_parser import acfp_pkg::*; #(
    parameter int MAX_PAYLOAD_BYTES = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_rx_char,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_frame_seq,
    output logic [31:0] o_frame_id,
    output logic [3:0]  o_frame_length,
    output logic [63:0] o_frame_payload,
    output logic [4:0]  o_error_flags,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    logic [7:0]  r_line_term;
    logic [31:0] r_seed;

    logic       st_valid;
    logic [7:0] st_char;
    logic       take;
    logic       is_term;
    logic       emit;
    logic       out_free;
    t_frame     pr_frame;
    t_frame     out_frame;

    // Configuration registers.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_term <= LINE_TERM_RESET;
            r_seed      <= SEED_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_LINE_TERM:     r_line_term <= i_cfg_data[7:0];
                CFG_CHECKSUM_SEED: r_seed      <= i_cfg_data;
                default: begin
                    r_seed <= r_seed;
                end
            endcase
        end
    end

    // A terminator moves on only when the output slot can take its frame.
    assign take = st_valid && (!is_term || out_free);

    acfp_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_char  (i_rx_char),
        .i_take  (take),
        .o_valid (st_valid),
        .o_char  (st_char)
    );

    acfp_parser #(
        .MAX_PAYLOAD_BYTES (MAX_PAYLOAD_BYTES)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_char      (st_char),
        .i_line_term (r_line_term),
        .i_seed      (r_seed),
        .o_is_term   (is_term),
        .o_emit      (emit),
        .o_frame     (pr_frame)
    );

    acfp_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (emit),
        .i_frame (pr_frame),
        .i_ready (i_out_ready),
        .o_valid (o_out_valid),
        .o_free  (out_free),
        .o_frame (out_frame)
    );

    assign o_frame_seq     = out_frame.seq;
    assign o_frame_id      = out_frame.id;
    assign o_frame_length  = out_frame.length;
    assign o_frame_payload = out_frame.payload;
    assign o_error_flags   = out_frame.err;

    // A delivered length never exceeds the payload capacity.
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_frame_length <= 4'(MAX_PAYLOAD_BYTES)))
        else $error("frame length above capacity");

    // A clamped length reads back as the capacity.
    a_len_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_error_flags[ERR_LENGTH])
        |-> (o_frame_length == 4'(MAX_PAYLOAD_BYTES)))
        else $error("length flag without clamped length");

    // Checksum, sequence and overrun flags only arise on complete lines.
    a_late_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_error_flags[ERR_CHECKSUM] || o_error_flags[ERR_SEQ]
            || o_error_flags[ERR_TOOMANY])) |-> !o_error_flags[ERR_EARLY])
        else $error("late error flag on an early line");

    // A terminator never overwrites a frame that is still waiting.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |-> !emit)
        else $error("frame overwritten while stalled");

endmodule

// ===== src/acfp_in_stage.sv =====
module acfp_in_stage import acfp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_char,
    input  logic       i_take,
    output logic       o_valid,
    output logic [7:0] o_char
);

    logic       r_valid;
    logic [7:0] r_char;

    // The register is free when empty or when its item moves on this cycle.
    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_char  = r_char;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Character holding register.
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_char <= i_char;
        end
    end

endmodule

// ===== src/acfp_parser.sv =====
module acfp_parser import acfp_pkg::*; #(
    parameter int MAX_PAYLOAD_BYTES = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_take,
    input  logic [7:0]  i_char,
    input  logic [7:0]  i_line_term,
    input  logic [31:0] i_seed,
    output logic        o_is_term,
    output logic        o_emit,
    output t_frame      o_frame
);

    localparam int PAY_W = 8 * MAX_PAYLOAD_BYTES;
    localparam int CNT_W = $clog2(MAX_PAYLOAD_BYTES + 1);
    localparam int IDX_W = (MAX_PAYLOAD_BYTES > 1) ? $clog2(MAX_PAYLOAD_BYTES) : 1;
    localparam logic [7:0] MAX_LEN = 8'(MAX_PAYLOAD_BYTES);

    t_phase             r_phase, n_phase;
    logic               r_high, n_high;
    logic [7:0]         r_byte, n_byte;
    logic [31:0]        r_sum, n_sum;
    logic [7:0]         r_rseq, n_rseq;
    logic [7:0]         r_eseq, n_eseq;
    logic [CNT_W-1:0]   r_didx, n_didx;
    logic [31:0]        r_id, n_id;
    logic [3:0]         r_len, n_len;
    logic [PAY_W-1:0]   r_pay, n_pay;
    logic [4:0]         r_err, n_err;
    logic [7:0]         r_fold;

    logic [3:0] nib;
    logic [7:0] full_byte;
    logic [7:0] clamped;
    logic [1:0] ph_off;

    // Low byte of the sum after two 16-bit and two 8-bit end-around folds.
    function automatic logic [7:0] fold_low(input logic [31:0] s);
        logic [31:0] s1, s2, s3, s4;
        s1 = s + (s >> 16);
        s2 = s1 + (s1 >> 16);
        s3 = s2 + (s2 >> 8);
        s4 = s3 + (s3 >> 8);
        return s4[7:0];
    endfunction

    assign o_is_term = (i_char == CHAR_CR) || (i_char == i_line_term);
    assign o_emit    = i_take && o_is_term;

    assign nib       = nibble_of(i_char);
    assign full_byte = r_byte | {4'h0, nib};
    assign clamped   = (full_byte > MAX_LEN) ? MAX_LEN : full_byte;
    assign ph_off    = 2'(3'(r_phase) - 3'(PH_ID0));

    // Frame as it stands when the terminator arrives.
    always_comb begin
        o_frame.seq     = r_rseq;
        o_frame.id      = r_id;
        o_frame.length  = r_len;
        o_frame.payload = 64'(r_pay);
        o_frame.err     = r_err;
        if (r_phase != PH_DONE) begin
            o_frame.err[ERR_EARLY] = 1'b1;
        end
    end

    // Next state of the parser for the character in the input register.
    always_comb begin
        n_phase = r_phase;
        n_high  = r_high;
        n_byte  = r_byte;
        n_sum   = r_sum;
        n_rseq  = r_rseq;
        n_eseq  = r_eseq;
        n_didx  = r_didx;
        n_id    = r_id;
        n_len   = r_len;
        n_pay   = r_pay;
        n_err   = r_err;
        if (i_take) begin
            if (o_is_term) begin
                n_phase = PH_SEQ;
                n_high  = 1'b1;
                n_byte  = 8'h00;
                n_sum   = i_seed;
                n_rseq  = 8'h00;
                n_didx  = '0;
                n_id    = 32'h0;
                n_len   = 4'h0;
                n_pay   = '0;
                n_err   = 5'h00;
            end else if (r_high) begin
                n_byte = {nib, 4'h0};
                n_high = 1'b0;
            end else begin
                n_byte = full_byte;
                n_high = 1'b1;
                case (r_phase)
                    PH_SEQ: begin
                        n_rseq  = full_byte;
                        n_sum   = r_sum + 32'(full_byte);
                        n_phase = PH_ID0;
                    end
                    PH_ID0, PH_ID1, PH_ID2, PH_ID3: begin
                        n_id[8*ph_off +: 8] = full_byte;
                        n_sum   = r_sum + 32'(full_byte);
                        n_phase = t_phase'(3'(r_phase) + 3'd1);
                    end
                    PH_LEN: begin
                        if (full_byte > MAX_LEN) begin
                            n_err[ERR_LENGTH] = 1'b1;
                        end
                        n_len   = clamped[3:0];
                        n_sum   = r_sum + 32'(clamped);
                        n_phase = PH_DATA;
                    end
                    PH_DATA: begin
                        if (r_didx < CNT_W'(r_len)) begin
                            n_pay[8*r_didx[IDX_W-1:0] +: 8] = full_byte;
                            n_sum  = r_sum + 32'(full_byte);
                            n_didx = r_didx + CNT_W'(1);
                        end else begin
                            // Checksum byte: compare and resync the sequence counter.
                            if (r_fold != full_byte) begin
                                n_err[ERR_CHECKSUM] = 1'b1;
                            end
                            if (r_eseq + 8'd1 != r_rseq) begin
                                n_err[ERR_SEQ] = 1'b1;
                            end
                            n_eseq  = r_rseq;
                            n_phase = PH_DONE;
                        end
                    end
                    PH_DONE: begin
                        n_err[ERR_TOOMANY] = 1'b1;
                    end
                    default: begin
                        n_phase = r_phase;
                    end
                endcase
            end
        end
    end

    // Parser state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SEQ;
            r_high  <= 1'b1;
            r_byte  <= 8'h00;
            r_sum   <= SEED_RESET;
            r_rseq  <= 8'h00;
            r_eseq  <= 8'h00;
            r_didx  <= '0;
            r_id    <= 32'h0;
            r_len   <= 4'h0;
            r_pay   <= '0;
            r_err   <= 5'h00;
        end else begin
            r_phase <= n_phase;
            r_high  <= n_high;
            r_byte  <= n_byte;
            r_sum   <= n_sum;
            r_rseq  <= n_rseq;
            r_eseq  <= n_eseq;
            r_didx  <= n_didx;
            r_id    <= n_id;
            r_len   <= n_len;
            r_pay   <= n_pay;
            r_err   <= n_err;
        end
    end

    // The folded checksum is registered from the sum. The checksum byte needs
    // two characters after the last summed byte, so the fold is always current.
    always_ff @(posedge i_clk) begin
        r_fold <= fold_low(r_sum);
    end

endmodule

// ===== src/acfp_out_reg.sv =====
module acfp_out_reg import acfp_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_load,
    input  t_frame i_frame,
    input  logic   i_ready,
    output logic   o_valid,
    output logic   o_free,
    output t_frame o_frame
);

    logic   r_valid;
    t_frame r_frame;

    // A new frame may enter when the slot is empty or is being emptied.
    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_frame = r_frame;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    // Frame holding register.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_frame <= i_frame;
        end
    end

endmodule
